// ===== rtl/bpfa_pkg.sv =====
`timescale 1ns / 1ps

package bpfa_pkg;

  localparam int PAGE_W    = 12;
  localparam int STAT_W    = 2;
  localparam int COUNT_W   = 13;
  localparam int MODE_W    = 2;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int WIDX_W    = PAGE_W - BIT_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_RESERVE = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_OOM      = 2'd1,
    ST_NOCHANGE = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_PAGE  = 2'd0,
    RD_FIRST = 2'd1,
    RD_NEXT  = 2'd2
  } rd_src_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    rd;
    rd_src_t rd_src;
    logic    modify;
    logic    alloc;
    logic    fixed;
    status_t fixed_status;
    logic    emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t mode;
    logic  in_range;
    logic  word_nz;
    logic  last;
  } sts_t;

endpackage

// ===== rtl/bpfa_if.sv =====
`timescale 1ns / 1ps

interface bpfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [11:0] page_number;

  modport source (output valid, output mode, output page_number, input ready);
  modport sink   (input valid, input mode, input page_number, output ready);
endinterface

interface bpfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] result_page;
  logic [1:0]  status;
  logic [12:0] free_pages;

  modport source (output valid, output result_page, output status, output free_pages,
                  input ready);
  modport sink   (input valid, input result_page, input status, input free_pages,
                  output ready);
endinterface

// ===== rtl/bitmap_page_frame_allocator_unit.sv =====
`timescale 1ns / 1ps
// Flow: free and reserve read the page's word (DISPATCH), update it (MODIFY), then emit;
//   no-op and out-of-range pages go to EMIT; allocate scans words up to the first nonzero
//   word (out of memory: every word). A stalled result beat holds the next item in EMIT.
// Throughput: one item at a time; the next beat is accepted the cycle after the result
//   is registered, so the allocate scan makes the slowest items.
// Reset (rst, synchronous): every page used, free count zero, both channels idle.

module bitmap_page_frame_allocator_unit
  import bpfa_pkg::*;
#(
  parameter int NUM_WORDS = 128
) (
  input  logic        clk,
  input  logic        rst,
  bpfa_req_if.sink    req,
  bpfa_rsp_if.source  rsp
);

  cmd_t cmd;
  sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpfa_datapath #(
    .NUM_WORDS (NUM_WORDS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (req.mode),
    .page_number (req.page_number),
    .result_page (rsp.result_page),
    .status      (rsp.status),
    .free_pages  (rsp.free_pages)
  );

endmodule

// ===== rtl/bpfa_datapath.sv =====
`timescale 1ns / 1ps

module bpfa_datapath
  import bpfa_pkg::*;
#(
  parameter int NUM_WORDS = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [MODE_W-1:0]   mode,
  input  logic [PAGE_W-1:0]   page_number,
  output logic [PAGE_W-1:0]   result_page,
  output logic [STAT_W-1:0]   status,
  output logic [COUNT_W-1:0]  free_pages
);

  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [WIDX_W:0] WORD_LIMIT = (WIDX_W + 1)'(NUM_WORDS);
  localparam logic [COUNT_W-1:0] PAGE_LIMIT = COUNT_W'(NUM_WORDS * WORD_BITS);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic                 vld [NUM_WORDS];

  mode_t                mode_q;
  logic [PAGE_W-1:0]    page_q;
  logic [AW-1:0]        rd_idx;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_vld;
  logic [COUNT_W-1:0]   count;
  logic [PAGE_W-1:0]    res_page;
  status_t              res_status;

  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] mask;
  logic                 hit;
  logic                 change;
  logic [BIT_W-1:0]     low_bit;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;

  assign word   = rd_vld ? rd_data : '0;
  assign mask   = WORD_BITS'(1) << page_q[BIT_W-1:0];
  assign hit    = |(word & mask);
  assign change = (mode_q == MODE_FREE) ? !hit : hit;

  always_comb begin
    low_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) low_bit = BIT_W'(i);
    end
  end

  always_comb begin
    case (cmd.rd_src)
      RD_PAGE:  rd_addr = page_q[BIT_W +: AW];
      RD_FIRST: rd_addr = '0;
      default:  rd_addr = rd_idx + AW'(1);
    endcase
  end

  always_comb begin
    wr_en   = cmd.alloc || (cmd.modify && change);
    wr_data = word & (word - WORD_BITS'(1));
    if (cmd.modify) begin
      wr_data = (mode_q == MODE_FREE) ? (word | mask) : (word & ~mask);
    end
  end

  assign sts.mode     = mode_q;
  assign sts.in_range = {1'b0, page_q[PAGE_W-1:BIT_W]} < WORD_LIMIT;
  assign sts.word_nz  = |word;
  assign sts.last     = rd_idx == AW'(NUM_WORDS - 1);

  // bitmap storage; an unwritten word reads as all used
  always_ff @(posedge clk) begin
    if (wr_en) mem[rd_idx] <= wr_data;
    if (cmd.rd) begin
      rd_idx  <= rd_addr;
      rd_data <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) vld[i] <= 1'b0;
      count <= '0;
    end else begin
      if (wr_en) vld[rd_idx] <= 1'b1;
      if (cmd.modify && change && mode_q == MODE_FREE) begin
        count <= count + COUNT_W'(1);
      end else if (wr_en && count != '0) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode_t'(mode);
      page_q <= page_number;
    end
    if (cmd.modify) begin
      res_page   <= page_q;
      res_status <= change ? ST_DONE : ST_NOCHANGE;
    end else if (cmd.alloc) begin
      res_page   <= {WIDX_W'(rd_idx), low_bit};
      res_status <= ST_DONE;
    end else if (cmd.fixed) begin
      res_page   <= (cmd.fixed_status == ST_OOM) ? '0 : page_q;
      res_status <= cmd.fixed_status;
    end
    if (cmd.emit) begin
      result_page <= res_page;
      status      <= res_status;
      free_pages  <= count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= PAGE_LIMIT)
    else $error("free count exceeds page total");

  a_count_source: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> $past(cmd.modify || cmd.alloc))
    else $error("free count moved without a bitmap update");

endmodule

// ===== rtl/bpfa_ctrl.sv =====
`timescale 1ns / 1ps

module bpfa_ctrl
  import bpfa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MODIFY,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = state == S_IDLE;

  always_comb begin
    cmd              = '0;
    cmd.rd_src       = RD_PAGE;
    cmd.fixed_status = ST_NOCHANGE;
    state_next       = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.mode)
          MODE_ALLOC: begin
            cmd.rd     = 1'b1;
            cmd.rd_src = RD_FIRST;
            state_next = S_SCAN;
          end
          MODE_NOP: begin
            cmd.fixed  = 1'b1;
            state_next = S_EMIT;
          end
          default: begin
            if (sts.in_range) begin
              cmd.rd     = 1'b1;
              state_next = S_MODIFY;
            end else begin
              cmd.fixed        = 1'b1;
              cmd.fixed_status = ST_RANGE;
              state_next       = S_EMIT;
            end
          end
        endcase
      end
      S_MODIFY: begin
        cmd.modify = 1'b1;
        state_next = S_EMIT;
      end
      S_SCAN: begin
        // one word a beat: examine the word just read, fetch the next
        if (sts.word_nz) begin
          cmd.alloc  = 1'b1;
          state_next = S_EMIT;
        end else if (sts.last) begin
          cmd.fixed        = 1'b1;
          cmd.fixed_status = ST_OOM;
          state_next       = S_EMIT;
        end else begin
          cmd.rd     = 1'b1;
          cmd.rd_src = RD_NEXT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && slot_free) |=> (out_valid && state == S_IDLE))
    else $error("result beat not presented after emit");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> $past(state == S_EMIT))
    else $error("result beat raised outside emit");

endmodule

// ===== tb/sv/bitmap_page_frame_allocator_unit_chk.sv =====
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_unit_chk
  import bpfa_pkg::*;
#(
  parameter int NUM_WORDS = 128
) (
  input  logic       clk,
  input  logic       rst,
  bpfa_req_if        req,
  bpfa_rsp_if        rsp,
  output int         errors,
  output int         outstanding
);

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } page_answer_t;

  logic [WORD_BITS-1:0] free_map [0:NUM_WORDS-1];
  logic [COUNT_W-1:0]   free_cnt;
  page_answer_t         pending_answers [$];

  // Apply one operation to the shadow bitmap and return the answer it gives.
  function automatic page_answer_t take_page_op(input mode_t op, input logic [PAGE_W-1:0] pg);
    page_answer_t ans;
    int           w;
    int           b;
    int           widx;
    ans.page   = pg;
    ans.status = ST_NOCHANGE;
    widx       = int'(pg) >> BIT_W;
    case (op)
      MODE_ALLOC: begin
        ans.page   = '0;
        ans.status = ST_OOM;
        for (w = 0; w < NUM_WORDS; w++) begin
          if (free_map[w] != '0) break;
        end
        if (w < NUM_WORDS) begin
          for (b = 0; b < WORD_BITS; b++) begin
            if (free_map[w][b]) break;
          end
          free_map[w][b] = 1'b0;
          if (free_cnt != '0) free_cnt = free_cnt - COUNT_W'(1);
          ans.page   = PAGE_W'(w * WORD_BITS + b);
          ans.status = ST_DONE;
        end
      end
      MODE_FREE, MODE_RESERVE: begin
        if (widx >= NUM_WORDS) begin
          ans.status = ST_RANGE;
        end else if (op == MODE_FREE && !free_map[widx][pg[BIT_W-1:0]]) begin
          free_map[widx][pg[BIT_W-1:0]] = 1'b1;
          free_cnt   = free_cnt + COUNT_W'(1);
          ans.status = ST_DONE;
        end else if (op == MODE_RESERVE && free_map[widx][pg[BIT_W-1:0]]) begin
          free_map[widx][pg[BIT_W-1:0]] = 1'b0;
          if (free_cnt != '0) free_cnt = free_cnt - COUNT_W'(1);
          ans.status = ST_DONE;
        end
      end
      default: ans.status = ST_NOCHANGE;
    endcase
    ans.count = free_cnt;
    return ans;
  endfunction

  always @(posedge clk) begin
    page_answer_t want;
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) free_map[i] = '0;
      free_cnt = '0;
      pending_answers.delete();
      errors      <= 0;
      outstanding <= 0;
    end else begin
      // Compare the result beat first; it always belongs to an earlier request.
      if (rsp.valid && rsp.ready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: result beat with nothing pending: page %0d status %0d count %0d",
                   $time, rsp.result_page, rsp.status, rsp.free_pages);
          errors <= errors + 1;
        end else begin
          want = pending_answers.pop_front();
          if (rsp.result_page !== want.page || rsp.status !== want.status ||
              rsp.free_pages !== want.count) begin
            if (rsp.result_page !== want.page)
              $display("%0t: result_page mismatch: expected %0d, got %0d",
                       $time, want.page, rsp.result_page);
            if (rsp.status !== want.status)
              $display("%0t: status mismatch: expected %0d, got %0d",
                       $time, want.status, rsp.status);
            if (rsp.free_pages !== want.count)
              $display("%0t: free_pages mismatch: expected %0d, got %0d",
                       $time, want.count, rsp.free_pages);
            errors <= errors + 1;
          end
        end
      end
      if (req.valid && req.ready)
        pending_answers.push_back(take_page_op(mode_t'(req.mode), req.page_number));
      outstanding <= pending_answers.size();
    end
  end

endmodule

// ===== tb/sv/bitmap_page_frame_allocator_unit_tb.sv =====
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_unit_tb;
  import bpfa_pkg::*;

  localparam int WORDS       = 128;
  localparam int RAND_PHASE  = 340;
  localparam int DRAIN_WAIT  = WORDS + 16;
  localparam int QUIET_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   outstanding;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   quiet_cycles;
  int   window_base;

  bpfa_req_if req_ch ();
  bpfa_rsp_if rsp_ch ();

  bitmap_page_frame_allocator_unit #(.NUM_WORDS(WORDS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  bitmap_page_frame_allocator_unit_chk #(.NUM_WORDS(WORDS)) chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Hold the request until it is taken; idle before it at the phase's rate.
  task automatic send_op(input mode_t op, input logic [PAGE_W-1:0] pg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= op;
    req_ch.page_number <= pg;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Pages near a moving window (45 percent) so frees and reserves hit their own work.
  function automatic void pick_op(output mode_t op, output logic [PAGE_W-1:0] pg);
    int r;
    int p;
    r = $urandom_range(0, 99);
    if (r < 30)      op = MODE_ALLOC;
    else if (r < 70) op = MODE_FREE;
    else if (r < 92) op = MODE_RESERVE;
    else             op = MODE_NOP;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      p = window_base + $urandom_range(0, 95);
      if (p > 4095) p = 4095;
    end else if (r < 60) begin
      case ($urandom_range(0, 4))
        0:       p = 0;
        1:       p = 31;
        2:       p = 32;
        3:       p = 4064;
        default: p = 4095;
      endcase
    end else begin
      p = $urandom_range(0, 4095);
    end
    pg = PAGE_W'(p);
  endfunction

  initial begin
    mode_t            op;
    logic [PAGE_W-1:0] pg;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.mode        <= MODE_ALLOC;
    req_ch.page_number <= '0;
    send_idle_pct      <= 0;
    recv_stall_pct     <= 0;
    window_base         = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty bitmap, extreme pages, double free, reserve both ways, no-op.
    send_op(MODE_ALLOC,   12'd0);
    send_op(MODE_RESERVE, 12'd5);
    send_op(MODE_FREE,    12'd0);
    send_op(MODE_FREE,    12'd4095);
    send_op(MODE_FREE,    12'd0);
    send_op(MODE_ALLOC,   12'd4095);
    send_op(MODE_ALLOC,   12'd0);
    send_op(MODE_ALLOC,   12'd0);
    send_op(MODE_FREE,    12'd5);
    send_op(MODE_RESERVE, 12'd5);
    send_op(MODE_RESERVE, 12'd5);
    send_op(MODE_FREE,    12'd31);
    send_op(MODE_FREE,    12'd32);
    send_op(MODE_FREE,    12'd2047);
    send_op(MODE_ALLOC,   12'd4095);
    send_op(MODE_NOP,     12'd4095);
    send_op(MODE_NOP,     12'd0);
    send_op(MODE_FREE,    12'd4095);
    send_op(MODE_RESERVE, 12'd4095);
    send_op(MODE_RESERVE, 12'd4095);
    send_op(MODE_ALLOC,   12'd0);
    send_op(MODE_ALLOC,   12'd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 83; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 83; end
        default: begin send_idle_pct <= 35; recv_stall_pct <= 35; end
      endcase
      for (int i = 0; i < RAND_PHASE; i++) begin
        if (i % 60 == 0) window_base = $urandom_range(0, 127) * WORD_BITS;
        pick_op(op, pg);
        send_op(op, pg);
      end
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bpfa_pkg.sv
rtl/bpfa_if.sv
rtl/bpfa_datapath.sv
rtl/bpfa_ctrl.sv
rtl/bitmap_page_frame_allocator_unit.sv
tb/sv/bitmap_page_frame_allocator_unit_chk.sv
tb/sv/bitmap_page_frame_allocator_unit_tb.sv
